FILE: rtl/pma_pkg.sv
// Shared types and constants for the prime modular arithmetic unit.
// Depends on nothing; every other file of the unit imports it.
`default_nettype none

package pma_pkg;

    localparam int unsigned A_W       = 30;
    localparam int unsigned B_W       = 31;
    localparam int unsigned R_W       = 30;
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned M_TDATA_W = 32;

    localparam logic [29:0] PRIME    = 30'd1000000007;
    localparam logic [30:0] PRIME_X2 = 31'd2000000014;

    // Barrett constant floor(2^60 / PRIME), which fits in 31 bits.
    localparam logic [63:0] MU_WIDE    = 64'h1000_0000_0000_0000 / 64'd1000000007;
    localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_POW = 2'd3
    } t_op;

    // Register that a finished modular product is written back to.
    typedef enum logic [1:0] {
        DEST_RES  = 2'd0,
        DEST_ACC  = 2'd1,
        DEST_BASE = 2'd2
    } t_dest;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic alu;
        logic issue_prod;
        logic issue_sqr;
        logic issue_acc;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic busy;
        logic exp_zero;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/pma_modmul.sv
// Pipelined multiplier modulo the prime with Barrett reduction, three register stages.
// Depends on pma_pkg for the prime, the Barrett constant and the destination tag.
`default_nettype none

module pma_modmul
    import pma_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [29:0] i_x,
    input  wire logic [29:0] i_y,
    input  wire t_dest       i_tag,
    output logic             o_valid,
    output t_dest            o_tag,
    output logic [29:0]      o_res,
    output logic             o_busy
);

    logic        r_v1, r_v2, r_v3;
    t_dest       r_tag1, r_tag2, r_tag3;
    logic [59:0] r_prod;
    logic [61:0] r_est;
    logic [31:0] r_plo2, r_plo3;
    logic [31:0] r_qp;

    logic [59:0] n_prod;
    logic [61:0] n_est;
    logic [30:0] w_q;
    logic [60:0] w_qp_full;
    logic [31:0] w_rem;

    assign n_prod    = i_x * i_y;
    assign n_est     = r_prod[59:29] * BARRETT_MU;
    assign w_q       = r_est[61:31];
    assign w_qp_full = w_q * PRIME;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_tag1 <= i_tag;
        r_est  <= n_est;
        r_plo2 <= r_prod[31:0];
        r_tag2 <= r_tag1;
        r_qp   <= w_qp_full[31:0];
        r_plo3 <= r_plo2;
        r_tag3 <= r_tag2;
    end

    // The estimate undershoots by at most two, so the remainder lies below three primes.
    assign w_rem = r_plo3 - r_qp;

    always_comb begin
        if (w_rem >= {1'b0, PRIME_X2}) begin
            o_res = 30'(w_rem - {1'b0, PRIME_X2});
        end else if (w_rem >= {2'b0, PRIME}) begin
            o_res = 30'(w_rem - {2'b0, PRIME});
        end else begin
            o_res = w_rem[29:0];
        end
    end

    assign o_valid = r_v3;
    assign o_tag   = r_tag3;
    assign o_busy  = r_v1 | r_v2 | r_v3;

    a_stage_flow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |=> r_v2)
        else $error("modmul: item lost between stage one and two");

    a_res_reduced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res < PRIME))
        else $error("modmul: Barrett result not fully reduced");

endmodule

`default_nettype wire

FILE: rtl/pma_dp.sv
// Datapath: operand reduction, add and subtract, the power registers and the output register.
// Depends on pma_pkg and instantiates pma_modmul.
`default_nettype none

module pma_dp
    import pma_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic [1:0]           i_s_tuser,
    output t_dp_stat                  o_stat,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata
);

    t_op         r_op;
    logic [29:0] r_raw_a;
    logic [30:0] r_raw_b;
    logic [29:0] r_a, r_b;
    logic [29:0] r_acc, r_base;
    logic [30:0] r_exp;
    logic [29:0] r_res;
    logic [29:0] r_out_res;
    logic        r_out_valid;

    logic [29:0] n_a, n_b, n_add, n_sub;
    logic [30:0] w_sum, w_diff;

    logic        w_mm_issue;
    logic [29:0] w_mm_x, w_mm_y;
    t_dest       w_mm_tag;
    logic        w_mm_valid;
    t_dest       w_mm_dest;
    logic [29:0] w_mm_res;
    logic        w_mm_busy;

    // Operand reduction: a stays below two primes, b below three.
    assign n_a = (r_raw_a >= PRIME) ? (r_raw_a - PRIME) : r_raw_a;

    always_comb begin
        if (r_raw_b >= PRIME_X2) begin
            n_b = 30'(r_raw_b - PRIME_X2);
        end else if (r_raw_b >= {1'b0, PRIME}) begin
            n_b = 30'(r_raw_b - {1'b0, PRIME});
        end else begin
            n_b = r_raw_b[29:0];
        end
    end

    assign w_sum  = {1'b0, r_a} + {1'b0, r_b};
    assign n_add  = (w_sum >= {1'b0, PRIME}) ? 30'(w_sum - {1'b0, PRIME}) : w_sum[29:0];
    assign w_diff = (r_a >= r_b) ? ({1'b0, r_a} - {1'b0, r_b})
                                 : ({1'b0, r_a} + {1'b0, PRIME} - {1'b0, r_b});
    assign n_sub  = w_diff[29:0];

    // Multiplier issue: the acc step only goes out when the current exponent bit is set.
    assign w_mm_issue = i_cmd.issue_prod | i_cmd.issue_sqr | (i_cmd.issue_acc & r_exp[0]);

    always_comb begin
        if (i_cmd.issue_sqr) begin
            w_mm_x   = r_base;
            w_mm_y   = r_base;
            w_mm_tag = DEST_BASE;
        end else if (i_cmd.issue_prod) begin
            w_mm_x   = r_a;
            w_mm_y   = r_b;
            w_mm_tag = DEST_RES;
        end else begin
            w_mm_x   = r_acc;
            w_mm_y   = r_base;
            w_mm_tag = DEST_ACC;
        end
    end

    pma_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mm_issue),
        .i_x     (w_mm_x),
        .i_y     (w_mm_y),
        .i_tag   (w_mm_tag),
        .o_valid (w_mm_valid),
        .o_tag   (w_mm_dest),
        .o_res   (w_mm_res),
        .o_busy  (w_mm_busy)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op    <= t_op'(i_s_tuser);
            r_raw_a <= i_s_tdata[29:0];
            r_raw_b <= i_s_tdata[60:30];
        end
        if (i_cmd.prep) begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_base <= n_a;
            r_acc  <= 30'd1;
            r_exp  <= r_raw_b;
        end
        if (i_cmd.issue_acc) begin
            r_exp <= r_exp >> 1;
        end
        if (i_cmd.alu) begin
            r_res <= (r_op == CMD_SUB) ? n_sub : n_add;
        end
        if (w_mm_valid) begin
            case (w_mm_dest)
                DEST_RES:  r_res  <= w_mm_res;
                DEST_ACC:  r_acc  <= w_mm_res;
                DEST_BASE: r_base <= w_mm_res;
                default:   r_res  <= w_mm_res;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_res <= (r_op == CMD_POW) ? r_acc : r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.busy     = w_mm_busy;
    assign o_stat.exp_zero = (r_exp == 31'd0);
    assign o_stat.out_free = ~r_out_valid | i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_res};

    a_prep_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.prep |-> !w_mm_busy)
        else $error("dp: operands reloaded while a product is in flight");

    a_out_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("dp: output register overwritten before it was taken");

    a_out_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (o_m_tvalid && (o_m_tdata[29:0] < PRIME)))
        else $error("dp: delivered result not reduced");

endmodule

`default_nettype wire

FILE: rtl/pma_ctrl.sv
// Controller state machine that sequences the datapath for each operation.
// Depends on pma_pkg for the command and status structs.
`default_nettype none

module pma_ctrl
    import pma_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_valid,
    input  wire t_dp_stat i_stat,
    output logic          o_s_ready,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PREP = 8'b0000_0010,
        S_ALU  = 8'b0000_0100,
        S_PROD = 8'b0000_1000,
        S_SQR  = 8'b0001_0000,
        S_MULT = 8'b0010_0000,
        S_WAIT = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_ready     = 1'b1;
                o_cmd.load_in = i_s_valid;
                if (i_s_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_stat.op inside {CMD_ADD, CMD_SUB}) begin
                    n_state = S_ALU;
                end else if (i_stat.op == CMD_MUL) begin
                    n_state = S_PROD;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_ALU: begin
                o_cmd.alu = 1'b1;
                n_state   = S_OUT;
            end
            S_PROD: begin
                o_cmd.issue_prod = 1'b1;
                n_state          = S_WAIT;
            end
            S_SQR: begin
                o_cmd.issue_sqr = 1'b1;
                n_state         = S_MULT;
            end
            S_MULT: begin
                o_cmd.issue_acc = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                // Leave once every product in flight has been written back.
                if (!i_stat.busy) begin
                    if (i_stat.op == CMD_POW && !i_stat.exp_zero) begin
                        n_state = S_SQR;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/prime_modular_arith_unit.sv
// Top level of the arithmetic unit modulo the prime 1000000007.
// Depends on pma_pkg and instantiates pma_ctrl and pma_dp.
//
// Channel   Direction  Signals                         Contents
// s_        in         i_s_tvalid/o_s_tready           tdata: operand_a, operand_b
//                                                      tuser: cmd
// m_        out        o_m_tvalid/i_m_tready           tdata: result
//
// Items are taken one at a time: a new item is accepted only after the previous result
// has been loaded into the output register.
// Power runs one exponent bit per round on the shared three-stage modular multiplier;
// each round issues the square and then, when the bit is set, the accumulator product.
// Reset is synchronous and active low; it clears the controller and the valid bits.
// A result held in the output register does not block the next item, but the next
// result waits in the controller until the output register has been taken.
`default_nettype none

module prime_modular_arith_unit
    import pma_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,   // [29:0] operand_a, [60:30] operand_b
    input  wire logic [1:0]           i_s_tuser,   // [1:0] cmd
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata    // [29:0] result
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    pma_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_stat    (w_stat),
        .o_s_ready (o_s_tready),
        .o_cmd     (w_cmd)
    );

    pma_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_stat     (w_stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire

FILE: bench/pma_result_checker.sv
// Scoreboard for the prime modular arithmetic unit: watches both stream channels.
// Depends on pma_pkg for the field widths, the prime and the operation codes.

module pma_result_checker
    import pma_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,   // [29:0] operand_a, [60:30] operand_b
    input  wire logic [1:0]           i_s_tuser,   // [1:0] cmd
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    input  wire logic [M_TDATA_W-1:0] i_m_tdata,   // [29:0] result
    output int                        o_mismatch_count,
    output int                        o_results_pending
);

    localparam longint unsigned MODULUS = 64'(PRIME);

    logic [R_W-1:0] expected_results[$];

    initial begin
        o_mismatch_count = 0;
        o_results_pending = 0;
    end

    // Operand a is reduced for every operation; operand b only where it is not an exponent.
    function automatic logic [R_W-1:0] modular_result(t_op op, logic [A_W-1:0] a_raw,
                                                      logic [B_W-1:0] b_raw);
        longint unsigned a;
        longint unsigned b;
        longint unsigned acc;
        longint unsigned base;
        a = a_raw % MODULUS;
        b = b_raw % MODULUS;
        case (op)
            CMD_ADD: acc = (a + b) % MODULUS;
            CMD_SUB: acc = (a + MODULUS - b) % MODULUS;
            CMD_MUL: acc = (a * b) % MODULUS;
            default: begin
                acc = 1;
                base = a;
                for (int k = 0; k < B_W; k++) begin
                    if (b_raw[k]) acc = (acc * base) % MODULUS;
                    base = (base * base) % MODULUS;
                end
            end
        endcase
        return acc[R_W-1:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        logic [R_W-1:0] want;
        if (i_rst_n && i_s_tvalid && i_s_tready) begin
            expected_results = {expected_results,
                                modular_result(t_op'(i_s_tuser), i_s_tdata[29:0],
                                               i_s_tdata[60:30])};
        end
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d with no item outstanding",
                                          i_m_tdata[29:0]));
            end else begin
                want = expected_results.pop_front();
                if (i_m_tdata[29:0] !== want)
                    report_mismatch($sformatf("result %0d, expected %0d",
                                              i_m_tdata[29:0], want));
            end
        end
        o_results_pending <= expected_results.size();
    end

endmodule

FILE: bench/prime_modular_arith_unit_tb.sv
// Testbench top for prime_modular_arith_unit: directed corner items, then random ones.
// Depends on pma_pkg, the unit itself and pma_result_checker, which does the comparing.

module prime_modular_arith_unit_tb;
    import pma_pkg::*;

    localparam int ITEM_COUNT  = 950;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 200;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   mismatch_count;
    int                   results_pending;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   cycle_count;

    prime_modular_arith_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    pma_result_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (s_tvalid),
        .i_s_tready        (s_tready),
        .i_s_tdata         (s_tdata),
        .i_s_tuser         (s_tuser),
        .i_m_tvalid        (m_tvalid),
        .i_m_tready        (m_tready),
        .i_m_tdata         (m_tdata),
        .o_mismatch_count  (mismatch_count),
        .o_results_pending (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Valid stays high from one item to the next unless an idle burst comes in between.
    task automatic push_operation(t_op op, logic [A_W-1:0] a, logic [B_W-1:0] b);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, b, a};
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic push_random_operation();
        t_op            op;
        logic [31:0]    rnd;
        logic [A_W-1:0] a;
        logic [B_W-1:0] b;
        int             exp_len;
        op = t_op'($urandom_range(0, 3));
        rnd = $urandom;
        case ($urandom_range(0, 3))
            0:       a = rnd[29:0];
            1:       a = PRIME + 30'($urandom_range(0, 16)) - 30'd8;
            default: a = 30'($urandom_range(0, 1000000006));
        endcase
        rnd = $urandom;
        if (op == CMD_POW) begin
            // Short exponents keep most power items quick; some use all 31 bits.
            exp_len = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 31);
            b = rnd[30:0] & ((31'd1 << exp_len) - 31'd1);
        end else if ($urandom_range(0, 2) == 0) begin
            b = rnd[30:0];
        end else begin
            b = 31'($urandom_range(0, 1000000006));
        end
        push_operation(op, a, b);
    endtask

    initial begin
        m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 99) < recv_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        cycle_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_ADD;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_operation(CMD_ADD, PRIME - 30'd1, 31'd1000000006);
        push_operation(CMD_ADD, 30'd0, 31'd0);
        push_operation(CMD_ADD, PRIME - 30'd1, 31'h7FFF_FFFF);
        push_operation(CMD_ADD, PRIME, 31'd1000000007);
        push_operation(CMD_SUB, 30'd0, 31'd1000000006);
        push_operation(CMD_SUB, PRIME - 30'd1, 31'd0);
        push_operation(CMD_SUB, 30'd5, 31'd5);
        push_operation(CMD_SUB, 30'd1, 31'h7FFF_FFFF);
        push_operation(CMD_MUL, PRIME - 30'd1, 31'd1000000006);
        push_operation(CMD_MUL, 30'h3FFF_FFFF, 31'h7FFF_FFFF);
        push_operation(CMD_MUL, 30'd0, 31'd123456789);
        push_operation(CMD_MUL, PRIME, 31'd3);
        // Zero exponent gives one for every base, zero included.
        push_operation(CMD_POW, 30'd0, 31'd0);
        push_operation(CMD_POW, PRIME - 30'd1, 31'd0);
        push_operation(CMD_POW, 30'd0, 31'd1);
        push_operation(CMD_POW, 30'd2, 31'd30);
        push_operation(CMD_POW, PRIME - 30'd1, 31'h7FFF_FFFF);
        push_operation(CMD_POW, 30'h3FFF_FFFF, 31'h7FFF_FFFF);
        push_operation(CMD_POW, PRIME, 31'd5);
        push_operation(CMD_POW, 30'd123456789, 31'h4000_0000);
        push_operation(CMD_POW, 30'd3, 31'd1000000006);

        for (int n = 0; n < ITEM_COUNT; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       send_idle_pct = 0;
                    1:       send_idle_pct = 20;
                    default: send_idle_pct = 60;
                endcase
                case ($urandom_range(0, 2))
                    0:       recv_idle_pct = 0;
                    1:       recv_idle_pct = 20;
                    default: recv_idle_pct = 60;
                endcase
            end
            if (n >= ITEM_COUNT - 100) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            push_random_operation();
        end
        s_tvalid <= 1'b0;

        // Wait for an edge so that the pending count includes the last accepted item.
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
